### hw/rtl/hoi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hoi_pkg;

  // Field widths
  localparam int VEL_W  = 24;
  localparam int DT_W   = 20;
  localparam int POS_W  = 48;
  localparam int ANG_W  = 32;
  localparam int TRIG_W = 32;

  // Shared multiplier: signed A by signed B
  localparam int MUL_A_W = 44;
  localparam int MUL_B_W = 25;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Rotated velocity (Q.32 m/s), per-tick displacement (Q.16 m)
  localparam int RX_W = 43;
  localparam int DP_W = 27;

  // CORDIC datapath width
  localparam int CORD_W = 34;

  localparam logic signed [CORD_W-1:0] GAIN_Q30    = 34'sd652032874;
  localparam logic signed [CORD_W-1:0] ONE_Q30     = 34'sd1073741824;
  localparam logic signed [CORD_W-1:0] NEG_ONE_Q30 = -34'sd1073741824;

  // Radians (2^-36) to binary angle scale, split for the narrow multiplier
  localparam logic [33:0] RAD_TO_TURN = 34'd10937044409;
  localparam logic [23:0] TURN_K_LO   = RAD_TO_TURN[23:0];
  localparam logic [9:0]  TURN_K_HI   = RAD_TO_TURN[33:24];

  // Half LSB of the displacement, for round half up
  localparam logic signed [MUL_P_W-1:0] DISP_RND = 69'sd34359738368;

  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  typedef struct packed {
    logic                     done;
    logic signed [TRIG_W-1:0] sin_v;
    logic signed [TRIG_W-1:0] cos_v;
  } hoi_trig_t;

  // atan(2^-i) as a binary angle
  function automatic logic [ANG_W-1:0] atan_step(input logic [4:0] idx);
    logic [ANG_W-1:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051D;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2E;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9;
      5'd15: v = 32'h0000517C;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A2F;
      5'd19: v = 32'h00000517;
      5'd20: v = 32'h0000028B;
      5'd21: v = 32'h00000145;
      5'd22: v = 32'h000000A2;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000028;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000002;
      5'd29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  function automatic logic signed [TRIG_W-1:0] clamp_q30(
    input logic signed [CORD_W-1:0] v
  );
    logic signed [TRIG_W-1:0] r;
    if (v > ONE_Q30) begin
      r = ONE_Q30[TRIG_W-1:0];
    end else if (v < NEG_ONE_Q30) begin
      r = NEG_ONE_Q30[TRIG_W-1:0];
    end else begin
      r = v[TRIG_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/hoi_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface hoi_in_if import hoi_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VEL_W-1:0] lin_vel_x;
  logic signed [VEL_W-1:0] lin_vel_y;
  logic signed [VEL_W-1:0] turn_rate;
  logic [DT_W-1:0]         elapsed;

  modport source (
    output valid, lin_vel_x, lin_vel_y, turn_rate, elapsed,
    input  ready
  );

  modport sink (
    input  valid, lin_vel_x, lin_vel_y, turn_rate, elapsed,
    output ready
  );
endinterface

`default_nettype wire

### hw/rtl/hoi_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface hoi_out_if import hoi_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  pos_x_out;
  logic signed [POS_W-1:0]  pos_y_out;
  logic [ANG_W-1:0]         heading_out;
  logic signed [TRIG_W-1:0] quat_z;
  logic signed [TRIG_W-1:0] quat_w;

  modport source (
    output valid, pos_x_out, pos_y_out, heading_out, quat_z, quat_w,
    input  ready
  );

  modport sink (
    input  valid, pos_x_out, pos_y_out, heading_out, quat_z, quat_w,
    output ready
  );
endinterface

`default_nettype wire

### hw/rtl/hoi_cordic.sv
`timescale 1ns / 1ps
`default_nettype none

// Iterative CORDIC, rotation mode: one micro-rotation per cycle.
module hoi_cordic import hoi_pkg::*; #(
  parameter int STEPS = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [ANG_W-1:0] angle,
  output hoi_trig_t        trig
);

  localparam logic [4:0] LAST_IDX = 5'(STEPS - 1);

  logic                     busy;
  logic                     done;
  logic                     flip;
  logic                     fold;
  logic [4:0]               idx;
  logic [ANG_W-1:0]         folded;
  logic signed [CORD_W-1:0] x, y, z;
  logic signed [CORD_W-1:0] x_sh, y_sh, atan_ext;
  logic signed [CORD_W-1:0] x_next, y_next, z_next;
  logic signed [CORD_W-1:0] x_fin, y_fin;

  always_comb begin
    // fold the second and third quadrants by a half turn
    fold   = (angle[ANG_W-1:ANG_W-2] == 2'b01) || (angle[ANG_W-1:ANG_W-2] == 2'b10);
    folded = angle ^ {fold, {(ANG_W-1){1'b0}}};

    x_sh     = x >>> idx;
    y_sh     = y >>> idx;
    atan_ext = $signed({{(CORD_W-ANG_W){1'b0}}, atan_step(idx)});

    if (!z[CORD_W-1]) begin
      x_next = x - y_sh;
      y_next = y + x_sh;
      z_next = z - atan_ext;
    end else begin
      x_next = x + y_sh;
      y_next = y - x_sh;
      z_next = z + atan_ext;
    end

    x_fin = flip ? -x : x;
    y_fin = flip ? -y : y;

    trig.done  = done;
    trig.cos_v = clamp_q30(x_fin);
    trig.sin_v = clamp_q30(y_fin);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      idx  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (busy) begin
        idx <= idx + 5'd1;
        if (idx == LAST_IDX) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      x    <= GAIN_Q30;
      y    <= '0;
      z    <= $signed({{(CORD_W-ANG_W){folded[ANG_W-1]}}, folded});
      flip <= fold;
    end else if (busy) begin
      x <= x_next;
      y <= y_next;
      z <= z_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/holonomic_odometry_integrator_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Planar dead-reckoning odometry integrator.
//
// tick (sink): one transaction per odometry tick carrying body forward and
// sideways velocity, yaw rate (all Q8.16) and the elapsed time (2^-20 s).
// pose (source): one transaction per tick with world X/Y (Q32.16, saturating),
// heading as a binary angle and the yaw quaternion z/w terms (Q1.30).
//
// A tick is accepted only while the block is idle, so the next tick is
// taken only after the pose of the last one has entered the output
// register. The two passes through the single iterative CORDIC unit
// (sin/cos of the old heading, then of the new half heading) take most
// of the work per tick; the nine products around them share one 44x25
// multiplier, one product per cycle.
//
// Reset clears position and heading to zero and drops any pending pose.
// The pose sits in an output register: while the receiver stalls, the next
// tick is still accepted and processed; it waits at its last step until the
// register is free.
module holonomic_odometry_integrator_core import hoi_pkg::*; #(
  parameter int CORDIC_STEPS = 24,
  parameter int ANGLE_BITS   = 32
) (
  input  logic      clk,
  input  logic      rst,
  hoi_in_if.sink    tick,
  hoi_out_if.source pose
);

  // heading keeps ANGLE_BITS significant bits; low bits of a step stay zero
  localparam logic [ANG_W-1:0] STEP_MASK =
    ~((ANG_W'(1) << (ANG_W - ANGLE_BITS)) - ANG_W'(1));

  typedef enum logic [3:0] {
    S_IDLE, S_ROT,
    S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8, S_M9, S_M10, S_M11,
    S_HEAD, S_QUAT, S_FINISH
  } state_t;

  state_t state;

  // latched tick
  logic signed [VEL_W-1:0]   vel_x, vel_y, rate;
  logic [DT_W-1:0]           dt;

  // arithmetic registers
  logic signed [TRIG_W-1:0]  cos_v, sin_v;
  logic signed [MUL_P_W-1:0] prod, acc;
  logic signed [RX_W-1:0]    rx, ry;
  logic signed [DP_W-1:0]    dpos;
  logic                      neg;
  logic [MUL_A_W-1:0]        mag;
  logic [ANG_W-1:0]          step;

  // pose state
  logic signed [POS_W-1:0]   pos_x, pos_y;
  logic [ANG_W-1:0]          heading;

  // CORDIC control
  logic                      cord_start;
  logic [ANG_W-1:0]          cord_angle;
  hoi_trig_t                 trig;

  // output register
  logic                      out_valid;
  logic signed [POS_W-1:0]   o_pos_x, o_pos_y;
  logic [ANG_W-1:0]          o_heading;
  logic signed [TRIG_W-1:0]  o_quat_z, o_quat_w;

  // combinational datapath
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] rot_diff, rot_sum, disp_sum;
  logic signed [POS_W-1:0]   pos_sel, pos_sat;
  logic signed [POS_W:0]     pos_sum;
  logic [MUL_A_W-1:0]        mag_abs;
  logic [71:0]               step_sum;
  logic [ANG_W-1:0]          head_next;
  logic                      accept;
  logic                      out_free;

  hoi_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cord_start),
    .angle (cord_angle),
    .trig  (trig)
  );

  assign tick.ready       = (state == S_IDLE);
  assign accept           = tick.valid && tick.ready;
  assign out_free         = !out_valid || pose.ready;

  assign pose.valid       = out_valid;
  assign pose.pos_x_out   = o_pos_x;
  assign pose.pos_y_out   = o_pos_y;
  assign pose.heading_out = o_heading;
  assign pose.quat_z      = o_quat_z;
  assign pose.quat_w      = o_quat_w;

  // Operand select for the shared multiplier. The product is registered in
  // prod and is consumed by the following state.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_M1: begin
        mul_a = {{(MUL_A_W-TRIG_W){cos_v[TRIG_W-1]}}, cos_v};
        mul_b = {{(MUL_B_W-VEL_W){vel_x[VEL_W-1]}}, vel_x};
      end
      S_M2: begin
        mul_a = {{(MUL_A_W-TRIG_W){sin_v[TRIG_W-1]}}, sin_v};
        mul_b = {{(MUL_B_W-VEL_W){vel_y[VEL_W-1]}}, vel_y};
      end
      S_M3: begin
        mul_a = {{(MUL_A_W-TRIG_W){sin_v[TRIG_W-1]}}, sin_v};
        mul_b = {{(MUL_B_W-VEL_W){vel_x[VEL_W-1]}}, vel_x};
      end
      S_M4: begin
        mul_a = {{(MUL_A_W-TRIG_W){cos_v[TRIG_W-1]}}, cos_v};
        mul_b = {{(MUL_B_W-VEL_W){vel_y[VEL_W-1]}}, vel_y};
      end
      S_M5: begin
        mul_a = {{(MUL_A_W-RX_W){rx[RX_W-1]}}, rx};
        mul_b = {{(MUL_B_W-DT_W){1'b0}}, dt};
      end
      S_M6: begin
        mul_a = {{(MUL_A_W-RX_W){ry[RX_W-1]}}, ry};
        mul_b = {{(MUL_B_W-DT_W){1'b0}}, dt};
      end
      S_M7: begin
        mul_a = {{(MUL_A_W-VEL_W){rate[VEL_W-1]}}, rate};
        mul_b = {{(MUL_B_W-DT_W){1'b0}}, dt};
      end
      S_M9: begin
        mul_a = mag;
        mul_b = {{(MUL_B_W-24){1'b0}}, TURN_K_LO};
      end
      S_M10: begin
        mul_a = mag;
        mul_b = {{(MUL_B_W-10){1'b0}}, TURN_K_HI};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    rot_diff = acc - prod;
    rot_sum  = acc + prod;
    disp_sum = prod + DISP_RND;

    // one saturating adder serves both axes
    pos_sel = (state == S_M7) ? pos_x : pos_y;
    pos_sum = $signed({pos_sel[POS_W-1], pos_sel}) + dpos;
    if (pos_sum[POS_W] != pos_sum[POS_W-1]) begin
      pos_sat = pos_sum[POS_W] ? POS_MIN : POS_MAX;
    end else begin
      pos_sat = pos_sum[POS_W-1:0];
    end

    mag_abs = prod[MUL_P_W-1] ? (~prod[MUL_A_W-1:0] + MUL_A_W'(1)) : prod[MUL_A_W-1:0];

    // |p| * scale = lo part + hi part << 24; keep bits 71..40
    step_sum  = {{(72-MUL_P_W){1'b0}}, acc} + {prod[47:0], 24'b0};
    head_next = neg ? (heading - step) : (heading + step);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cord_start <= 1'b0;
      out_valid  <= 1'b0;
      pos_x      <= '0;
      pos_y      <= '0;
      heading    <= '0;
    end else begin
      cord_start <= 1'b0;
      prod       <= mul_a * mul_b;
      if (pose.valid && pose.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            vel_x      <= tick.lin_vel_x;
            vel_y      <= tick.lin_vel_y;
            rate       <= tick.turn_rate;
            dt         <= tick.elapsed;
            cord_angle <= heading;
            cord_start <= 1'b1;
            state      <= S_ROT;
          end
        end
        S_ROT: begin
          // hold until sin/cos of the old heading are ready
          if (trig.done) begin
            cos_v <= trig.cos_v;
            sin_v <= trig.sin_v;
            state <= S_M1;
          end
        end
        S_M1: state <= S_M2;
        S_M2: begin
          acc   <= prod;
          state <= S_M3;
        end
        S_M3: begin
          rx    <= rot_diff[RX_W+13:14];
          state <= S_M4;
        end
        S_M4: begin
          acc   <= prod;
          state <= S_M5;
        end
        S_M5: begin
          ry    <= rot_sum[RX_W+13:14];
          state <= S_M6;
        end
        S_M6: begin
          dpos  <= disp_sum[DP_W+35:36];
          state <= S_M7;
        end
        S_M7: begin
          pos_x <= pos_sat;
          dpos  <= disp_sum[DP_W+35:36];
          state <= S_M8;
        end
        S_M8: begin
          pos_y <= pos_sat;
          neg   <= prod[MUL_P_W-1];
          mag   <= mag_abs;
          state <= S_M9;
        end
        S_M9: state <= S_M10;
        S_M10: begin
          acc   <= prod;
          state <= S_M11;
        end
        S_M11: begin
          step  <= step_sum[71:40] & STEP_MASK;
          state <= S_HEAD;
        end
        S_HEAD: begin
          heading    <= head_next;
          cord_angle <= head_next >> 1;
          cord_start <= 1'b1;
          state      <= S_QUAT;
        end
        S_QUAT: begin
          if (trig.done) begin
            if (out_free) begin
              o_pos_x   <= pos_x;
              o_pos_y   <= pos_y;
              o_heading <= heading;
              o_quat_z  <= trig.sin_v;
              o_quat_w  <= trig.cos_v;
              out_valid <= 1'b1;
              state     <= S_IDLE;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          // the CORDIC holds its result; wait for the output register
          if (out_free) begin
            o_pos_x   <= pos_x;
            o_pos_y   <= pos_y;
            o_heading <= heading;
            o_quat_z  <= trig.sin_v;
            o_quat_w  <= trig.cos_v;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_heading_lsbs: assert property (@(posedge clk) disable iff (rst)
    (heading & ~STEP_MASK) == '0)
    else $error("heading carries bits below its angle resolution");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (cord_start && state == S_ROT))
    else $error("accepted tick did not launch the heading rotation");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    trig.done |-> (state == S_ROT || state == S_QUAT))
    else $error("CORDIC finished outside a wait state");

endmodule

`default_nettype wire

### tb/odometry_pose_checker.sv
`timescale 1ns / 1ps

module odometry_pose_checker import hoi_pkg::*; #(
  parameter int CORDIC_STEPS = 24,
  parameter int ANGLE_BITS   = 32
) (
  input  logic clk,
  input  logic rst,
  hoi_in_if    tick,
  hoi_out_if   pose,
  output int   mismatches,
  output int   pending
);

  localparam longint POS_HI      = 64'sd140737488355327;
  localparam longint POS_LO      = -64'sd140737488355328;
  localparam longint Q30_ONE     = 64'sd1073741824;
  localparam longint CORDIC_GAIN = 64'sd652032874;
  localparam longint DISP_HALF   = 64'sd34359738368;
  localparam logic [127:0] RAD_TURN_SCALE = 128'd10937044409;
  localparam int TURN_SHIFT = 40 + 32 - ANGLE_BITS;

  localparam logic [31:0] ATAN_TURN [0:31] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
    32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
  };

  typedef struct packed {
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [ANG_W-1:0]  heading;
    logic [TRIG_W-1:0] quat_z;
    logic [TRIG_W-1:0] quat_w;
  } pose_t;

  // predicted odometry state
  longint           pos_x_q;
  longint           pos_y_q;
  logic [ANG_W-1:0] heading_q;

  pose_t pose_expected[$];
  pose_t want;
  int    poses_checked;

  function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // CORDIC rotation; fold the angle into [-1/4, 1/4) turn first
  function automatic void sin_cos_q30(input logic [ANG_W-1:0] angle,
                                      output longint sin_q, output longint cos_q);
    logic [ANG_W-1:0] a;
    logic   mirrored;
    longint x, y, z, dx, dy;
    int     i;
    a = angle;
    mirrored = (a[31:30] == 2'b01) || (a[31:30] == 2'b10);
    if (mirrored) begin
      a[31] = ~a[31];
    end
    x = CORDIC_GAIN;
    y = 0;
    z = longint'($signed(a));
    for (i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(ATAN_TURN[i]);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(ATAN_TURN[i]);
      end
    end
    if (mirrored) begin
      x = -x;
      y = -y;
    end
    cos_q = clamp_to(x, -Q30_ONE, Q30_ONE);
    sin_q = clamp_to(y, -Q30_ONE, Q30_ONE);
  endfunction

  // Advance the pose by one tick; motion uses the heading before the turn.
  function automatic pose_t integrate_tick(input logic signed [VEL_W-1:0] vel_x,
                                           input logic signed [VEL_W-1:0] vel_y,
                                           input logic signed [VEL_W-1:0] rate,
                                           input logic [DT_W-1:0] dt_in);
    longint vx, vy, w, dt, s, c, rx, ry, dx, dy, p;
    longint qz, qw;
    logic [127:0] turn_prod;
    logic [127:0] turn_q;
    logic [ANG_W-1:0] step;
    pose_t r;
    vx = longint'(vel_x);
    vy = longint'(vel_y);
    w  = longint'(rate);
    dt = longint'({44'd0, dt_in});
    sin_cos_q30(heading_q, s, c);
    rx = (vx * c - vy * s) >>> 14;
    ry = (vx * s + vy * c) >>> 14;
    dx = (rx * dt + DISP_HALF) >>> 36;
    dy = (ry * dt + DISP_HALF) >>> 36;
    pos_x_q = clamp_to(pos_x_q + dx, POS_LO, POS_HI);
    pos_y_q = clamp_to(pos_y_q + dy, POS_LO, POS_HI);

    p = w * dt;
    turn_prod = {64'd0, (p < 0) ? -p : p} * RAD_TURN_SCALE;
    turn_q = (turn_prod >> TURN_SHIFT) << (32 - ANGLE_BITS);
    step = turn_q[ANG_W-1:0];
    heading_q = (p < 0) ? heading_q - step : heading_q + step;

    sin_cos_q30(heading_q >> 1, qz, qw);
    r.pos_x   = pos_x_q[POS_W-1:0];
    r.pos_y   = pos_y_q[POS_W-1:0];
    r.heading = heading_q;
    r.quat_z  = qz[TRIG_W-1:0];
    r.quat_w  = qw[TRIG_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_v);
    if (mismatches < 40) begin
      $display("[%0t] pose %0d: %s got %0h, expected %0h", $realtime, poses_checked,
               what, got, exp_v);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pos_x_q = 0;
      pos_y_q = 0;
      heading_q = '0;
      pose_expected.delete();
      poses_checked = 0;
      mismatches = 0;
      pending <= 0;
    end else begin
      // compare before predicting: a pose never belongs to a tick of the same edge
      if (pose.valid && pose.ready) begin
        if (pose_expected.size() == 0) begin
          report_mismatch("unexpected transaction, pos_x_out", 64'(pose.pos_x_out), 64'd0);
        end else begin
          want = pose_expected.pop_front();
          if (pose.pos_x_out !== want.pos_x)
            report_mismatch("pos_x_out", 64'(pose.pos_x_out), 64'(want.pos_x));
          if (pose.pos_y_out !== want.pos_y)
            report_mismatch("pos_y_out", 64'(pose.pos_y_out), 64'(want.pos_y));
          if (pose.heading_out !== want.heading)
            report_mismatch("heading_out", 64'(pose.heading_out), 64'(want.heading));
          if (pose.quat_z !== want.quat_z)
            report_mismatch("quat_z", 64'(pose.quat_z), 64'(want.quat_z));
          if (pose.quat_w !== want.quat_w)
            report_mismatch("quat_w", 64'(pose.quat_w), 64'(want.quat_w));
        end
        poses_checked++;
      end
      if (tick.valid && tick.ready) begin
        pose_expected.push_back(integrate_tick(tick.lin_vel_x, tick.lin_vel_y,
                                               tick.turn_rate, tick.elapsed));
      end
      pending <= pose_expected.size();
    end
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench import hoi_pkg::*; ();

  localparam int STEPS = 24;
  localparam int ABITS = 32;
  // time between ticks at full rate
  localparam int TICK_CYCLES  = 2 * STEPS + 17;
  localparam int RANDOM_TICKS = 1200;
  // long receiver hold-off: the output register and the tick in flight fill
  // up, and the tick channel has to stall
  localparam int HOLD_AFTER  = 300;
  localparam int HOLD_CYCLES = 2000;
  // slowest legal run is ~1220 ticks, each at full tick time plus the longest
  // sender gap and receiver stall, plus the hold; allow about four times that
  localparam int CYCLE_LIMIT = 600000;

  localparam logic signed [VEL_W-1:0] VEL_MAX = 24'sh7FFFFF;
  localparam logic signed [VEL_W-1:0] VEL_MIN = 24'sh800000;
  // about pi/2 rad/s in Q8.16: a quarter turn per tick at the longest step
  localparam logic signed [VEL_W-1:0] QUARTER_RATE = 24'sd102944;
  localparam logic [DT_W-1:0] DT_MAX = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycles = 0;
  int   ticks_sent = 0;
  int   poses_taken = 0;
  int   mismatches;
  int   pending;

  hoi_in_if  tick_if ();
  hoi_out_if pose_if ();

  holonomic_odometry_integrator_core #(
    .CORDIC_STEPS(STEPS),
    .ANGLE_BITS  (ABITS)
  ) DUT (
    .clk (clk),
    .rst (rst),
    .tick(tick_if),
    .pose(pose_if)
  );

  odometry_pose_checker #(
    .CORDIC_STEPS(STEPS),
    .ANGLE_BITS  (ABITS)
  ) u_pose_check (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick_if),
    .pose      (pose_if),
    .mismatches(mismatches),
    .pending   (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hard stop in case the block hangs or stops answering.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Offer one tick and hold it until the block takes it. Every third window
  // of 150 ticks runs back to back; otherwise a random gap, possibly none,
  // comes first. Valid only drops when a gap follows, so it is never
  // lowered and raised in the same step.
  task automatic offer_tick(input logic signed [VEL_W-1:0] vx,
                            input logic signed [VEL_W-1:0] vy,
                            input logic signed [VEL_W-1:0] w,
                            input logic [DT_W-1:0] dt);
    int gap;
    gap = ((ticks_sent / 150) % 3 == 2) ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      tick_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_if.valid     <= 1'b1;
    tick_if.lin_vel_x <= vx;
    tick_if.lin_vel_y <= vy;
    tick_if.turn_rate <= w;
    tick_if.elapsed   <= dt;
    do @(posedge clk); while (!tick_if.ready);
    ticks_sent++;
  endtask

  // Pick one of the field corners: both ends, zero and +/-1 LSB.
  function automatic logic signed [VEL_W-1:0] corner_vel();
    case ($urandom_range(0, 4))
      0: return VEL_MAX;
      1: return VEL_MIN;
      2: return '0;
      3: return '1;
      default: return 24'sd1;
    endcase
  endfunction

  // Receiver: a random stall, possibly none, before each pose, with
  // back-to-back windows, and one long hold-off while the sender keeps pushing ticks.
  initial begin
    int stall;
    wait (!rst);
    forever begin
      stall = ((poses_taken / 170) % 3 == 1) ? 0 : $urandom_range(0, 18);
      if (poses_taken == HOLD_AFTER) begin
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        pose_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pose_if.ready <= 1'b1;
      do @(posedge clk); while (!pose_if.valid);
      poses_taken++;
    end
  end

  // Stimulus and verdict.
  initial begin
    logic signed [VEL_W-1:0] vx, vy, w;
    logic [DT_W-1:0] dt;
    int n;

    tick_if.valid     <= 1'b0;
    tick_if.lin_vel_x <= '0;
    tick_if.lin_vel_y <= '0;
    tick_if.turn_rate <= '0;
    tick_if.elapsed   <= '0;
    pose_if.ready     <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed ticks. Start from rest, then zero elapsed time with every
    // field at its top: the pose must not move but a result still comes.
    offer_tick('0, '0, '0, '0);
    offer_tick(VEL_MAX, VEL_MAX, VEL_MAX, '0);
    // straight runs along each axis at heading zero, longest step
    offer_tick(VEL_MAX, '0, '0, DT_MAX);
    offer_tick('0, VEL_MIN, '0, DT_MAX);
    // turn while moving: the displacement must use the heading held before
    // the tick, then step through all four quadrants of the sine fold
    offer_tick(VEL_MIN, VEL_MAX, QUARTER_RATE, DT_MAX);
    repeat (4) offer_tick(VEL_MAX, 24'sh123456, QUARTER_RATE, DT_MAX);
    repeat (3) offer_tick(24'shF00000, VEL_MAX, -QUARTER_RATE, DT_MAX);
    // fastest spin either way: heading wraps many times over a full turn
    offer_tick(VEL_MAX, VEL_MAX, VEL_MAX, DT_MAX);
    offer_tick(VEL_MIN, VEL_MIN, VEL_MIN, DT_MAX);
    // single-LSB values: rounding of tiny displacements and heading steps
    offer_tick('1, 24'sd1, 24'sd1, 20'd1);
    offer_tick(24'sd1, '1, '1, DT_MAX);
    offer_tick('1, '1, '1, DT_MAX);
    // alternating bit patterns
    offer_tick(24'sh555555, 24'shAAAAAA, 24'sh555555, 20'hAAAAA);
    offer_tick(24'shAAAAAA, 24'sh555555, 24'shAAAAAA, 20'h55555);
    offer_tick(VEL_MIN, '0, VEL_MAX, 20'h80000);

    // Random ticks. Position saturation lies some 2^24 full-speed ticks out,
    // far past any run; the rest of the field space is spread below.
    for (n = 0; n < RANDOM_TICKS; n++) begin
      vx = VEL_W'($urandom);
      vy = VEL_W'($urandom);
      w  = VEL_W'($urandom);
      dt = DT_W'($urandom);
      case ($urandom_range(0, 9))
        6: dt = '0;
        7: begin
          vx = corner_vel();
          vy = corner_vel();
          w  = corner_vel();
          if ($urandom_range(0, 1) == 1) dt = DT_MAX;
        end
        8: dt = DT_W'($urandom_range(0, 255));
        9: dt = DT_MAX;
        default: ;
      endcase
      offer_tick(vx, vy, w, dt);
    end
    tick_if.valid <= 1'b0;

    // Drain: wait for every predicted pose, then give the block a full tick
    // time to show any stray transaction.
    do @(posedge clk); while (pending != 0);
    repeat (TICK_CYCLES + 8) @(posedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
